@@ src/mbc_pkg.sv @@
`default_nettype none

package mbc_pkg;

    localparam int MAX_FACE_SIZE = 2048;
    localparam int MAX_LEVELS    = 12;
    localparam int NUM_LOWER     = MAX_LEVELS - 1;

    localparam int SIZE_W  = $clog2(MAX_FACE_SIZE) + 1;
    localparam int CNT_W   = $clog2(MAX_FACE_SIZE);
    localparam int ADDR_W  = $clog2(MAX_FACE_SIZE);
    localparam int LVL_W   = 4;
    localparam int COORD_W = 10;
    localparam int LANE_W  = 9;
    localparam int PAIR_W  = 4 * LANE_W;
    localparam int PIX_W   = 32;

    typedef logic [PAIR_W-1:0] pair_t;
    typedef logic [PIX_W-1:0]  pix_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        pair_t             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    function automatic pair_t pix_to_lanes(input pix_t p);
        pair_t r;
        r = {1'b0, p[31:24], 1'b0, p[23:16], 1'b0, p[15:8], 1'b0, p[7:0]};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/mbc_pair_ram.sv @@
`default_nettype none

module mbc_pair_ram
    import mbc_pkg::*;
(
    input  wire logic     clk,
    input  wire ram_req_t req,
    output pair_t         rdata
);

    pair_t mem [MAX_FACE_SIZE];
    pair_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/mbc_avg_unit.sv @@
`default_nettype none

module mbc_avg_unit
    import mbc_pkg::*;
(
    input  wire pair_t a,
    input  wire pair_t b,
    output pair_t      sum_pair,
    output pix_t       avg
);

    always_comb
    begin
        logic [LANE_W:0] s;
        sum_pair = '0;
        avg      = '0;
        for (int k = 0; k < 4; k++)
        begin
            s = {1'b0, a[k*LANE_W +: LANE_W]} + {1'b0, b[k*LANE_W +: LANE_W]};
            sum_pair[k*LANE_W +: LANE_W] = s[LANE_W-1:0];
            avg[k*8 +: 8] = 8'((s + 10'd2) >> 2);
        end
    end

endmodule

`default_nettype wire

@@ src/box_filter_mip_chain_top.sv @@
// Streaming 2x2 box-filter mip chain generator for one square RGBA8 face.
// Base-level pixels enter on the s_ channel in raster order; every finished
// lower-level pixel leaves on the m_ channel with its level and position,
// and m_tlast marks the final beat caused by one input pixel.
// The APB port holds face_size (address 0) and mip_enable (address 4); a
// write to either restarts the raster position of every level.
// One shared adder unit does the work, one level per pass: a level that
// produces no pixel passes only the evaluate step, a level that produces
// one also passes the averaging step (pair-sum memory read, then averaging),
// and a beat that produces any result ends with a flush step that releases
// its last result. An input beat may complete up to all eleven levels, and
// s_tready stays low meanwhile; the last result reaches m_tvalid as s_tready
// rises again.
// With mip_enable at 0 or a face size of one, a beat is taken every cycle.
// Results pass through a one-entry hold and an output register, so a
// stalled m_tready only holds the sequencer once both are full.
// Reset clears the counters and the output register; face_size resets to
// 1 and mip_enable to 0, so nothing is emitted until it is set.
`default_nettype none

module box_filter_mip_chain_top
    import mbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // red, green, blue, alpha
    input  wire logic [2:0]  s_tuser,   // face
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // level, col, row, red_out, green_out, blue_out, alpha_out
    output logic [2:0]       m_tuser,   // face_out
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_AVG   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam logic REG_FACE_SIZE  = 1'b0;
    localparam logic REG_MIP_ENABLE = 1'b1;

    logic [SIZE_W-1:0] face_size_reg;
    logic              mip_en_reg;

    logic [1:0]         state_reg, state_next;
    logic [LVL_W-1:0]   lvl_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  off_reg;
    pix_t               pix_reg;
    logic [2:0]         face_reg;
    pair_t              pair_reg;
    logic [COORD_W-1:0] ccol_reg, crow_reg;

    logic        pend_valid_reg;
    logic [55:0] pend_data_reg;

    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic [2:0]  out_face_reg;
    logic        out_last_reg;

    logic [CNT_W-1:0] col_cnt_reg [NUM_LOWER];
    logic [CNT_W-1:0] row_cnt_reg [NUM_LOWER];
    pix_t             hold_reg    [NUM_LOWER];

    logic cfg_wr;
    logic accept;
    logic [SIZE_W-1:0] eff_size;

    logic [CNT_W-1:0]  c, r;
    logic [CNT_W-1:0]  col_next, row_next;
    logic [SIZE_W-1:0] even_span;
    logic              in_region, go_avg;
    logic [SIZE_W-2:0] half;
    logic [ADDR_W-1:0] idx, off_step;
    logic              out_free, out_load, out_load_last;
    logic              next_level;

    pair_t    unit_a, unit_b, unit_sum;
    pix_t     unit_avg;
    pair_t    ram_rdata;
    ram_req_t ram_req;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        case (paddr[2])
            REG_FACE_SIZE:  prdata = 32'(face_size_reg);
            REG_MIP_ENABLE: prdata = 32'(mip_en_reg);
            default:        prdata = '0;
        endcase
    end

    always_comb
    begin
        if (face_size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (face_size_reg > SIZE_W'(MAX_FACE_SIZE))
        begin
            eff_size = SIZE_W'(MAX_FACE_SIZE);
        end
        else
        begin
            eff_size = face_size_reg;
        end
    end

    assign c         = col_cnt_reg[lvl_reg];
    assign r         = row_cnt_reg[lvl_reg];
    assign half      = size_reg[SIZE_W-1:1];
    assign even_span = {half, 1'b0};
    assign in_region = ({1'b0, c} < even_span) && ({1'b0, r} < even_span);
    assign go_avg    = in_region && c[0] && r[0];
    assign idx       = ADDR_W'(off_reg + {1'b0, c[CNT_W-1:1]});
    assign off_step  = ADDR_W'(SIZE_W'(MAX_FACE_SIZE) >> (lvl_reg + LVL_W'(1)));
    assign next_level = (lvl_reg + LVL_W'(1) < LVL_W'(NUM_LOWER)) && (half >= (SIZE_W-1)'(2));

    always_comb
    begin
        if ({1'b0, c} + SIZE_W'(1) >= size_reg)
        begin
            col_next = '0;
            row_next = ({1'b0, r} + SIZE_W'(1) >= size_reg) ? '0 : CNT_W'(r + CNT_W'(1));
        end
        else
        begin
            col_next = CNT_W'(c + CNT_W'(1));
            row_next = r;
        end
    end

    always_comb
    begin
        if (state_reg == ST_AVG)
        begin
            unit_a = ram_rdata;
            unit_b = pair_reg;
        end
        else
        begin
            unit_a = pix_to_lanes(hold_reg[lvl_reg]);
            unit_b = pix_to_lanes(pix_reg);
        end
    end

    mbc_avg_unit u_unit (
        .a        (unit_a),
        .b        (unit_b),
        .sum_pair (unit_sum),
        .avg      (unit_avg)
    );

    always_comb
    begin
        ram_req       = '0;
        ram_req.waddr = idx;
        ram_req.raddr = idx;
        ram_req.wdata = unit_sum;
        if (state_reg == ST_EVAL && in_region && c[0])
        begin
            ram_req.we = !r[0];
            ram_req.re = r[0];
        end
    end

    mbc_pair_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        out_load      = 1'b0;
        out_load_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mip_en_reg && eff_size >= SIZE_W'(2))
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (go_avg)
                begin
                    state_next = ST_AVG;
                end
                else if (pend_valid_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_AVG:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    out_load   = pend_valid_reg;
                    state_next = next_level ? ST_EVAL : ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_load_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            face_size_reg  <= SIZE_W'(1);
            mip_en_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_LOWER; i++)
            begin
                col_cnt_reg[i] <= '0;
                row_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                case (paddr[2])
                    REG_FACE_SIZE:  face_size_reg <= pwdata[SIZE_W-1:0];
                    REG_MIP_ENABLE: mip_en_reg    <= pwdata[0];
                    default:        mip_en_reg    <= mip_en_reg;
                endcase
                for (int i = 0; i < NUM_LOWER; i++)
                begin
                    col_cnt_reg[i] <= '0;
                    row_cnt_reg[i] <= '0;
                end
            end
            else if (state_reg == ST_EVAL)
            begin
                col_cnt_reg[lvl_reg] <= col_next;
                row_cnt_reg[lvl_reg] <= row_next;
            end
            if (state_reg == ST_AVG && state_next != ST_AVG)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (state_reg == ST_FLUSH && state_next == ST_IDLE)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            pix_reg  <= s_tdata;
            face_reg <= s_tuser;
            lvl_reg  <= '0;
            size_reg <= eff_size;
            off_reg  <= '0;
        end
        if (state_reg == ST_EVAL)
        begin
            if (in_region && !c[0])
            begin
                hold_reg[lvl_reg] <= pix_reg;
            end
            pair_reg <= unit_sum;
            ccol_reg <= COORD_W'(c >> 1);
            crow_reg <= COORD_W'(r >> 1);
        end
        if (state_reg == ST_AVG && state_next != ST_AVG)
        begin
            pend_data_reg <= {unit_avg, crow_reg, ccol_reg, LVL_W'(lvl_reg + LVL_W'(1))};
            pix_reg       <= unit_avg;
            lvl_reg       <= LVL_W'(lvl_reg + LVL_W'(1));
            size_reg      <= {1'b0, half};
            off_reg       <= ADDR_W'(off_reg + off_step);
        end
        if (out_load)
        begin
            out_data_reg <= pend_data_reg;
            out_face_reg <= face_reg;
            out_last_reg <= out_load_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_face_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none

module tb
    import mbc_pkg::*;
();

    localparam logic [2:0] ADDR_FACE_SIZE  = 3'd0;
    localparam logic [2:0] ADDR_MIP_ENABLE = 3'd4;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [2:0] face;
        logic [3:0] level;
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } mip_pixel_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [PAIR_W-1:0] pair_sum_mem [MAX_FACE_SIZE];
    logic [31:0]       left_pix     [MAX_LEVELS];
    int unsigned       col_pos      [MAX_LEVELS];
    int unsigned       row_pos      [MAX_LEVELS];
    logic [11:0]       model_size   = 12'd1;
    logic              model_enable = 1'b0;

    mip_pixel_t mip_expected [$];
    int         mismatches   = 0;
    bit         idle_on      = 1'b1;
    int         stall_request = 0;

    box_filter_mip_chain_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // Works out the lower-level pixels that one accepted base pixel completes.
    task automatic predict_mips(input logic [2:0] face, input logic [31:0] pix_in);
        int unsigned size;
        int unsigned half;
        int unsigned c;
        int unsigned r;
        int unsigned offs;
        int unsigned idx;
        int unsigned t;
        int          l;
        int          k;
        int          first;
        logic [31:0] pix;
        logic [31:0] avg;
        logic [PAIR_W-1:0] pair;
        bit          produced;
        mip_pixel_t  res;
        if (!model_enable)
            return;
        size = (model_size == 0) ? 1 : model_size;
        if (size > MAX_FACE_SIZE)
            size = MAX_FACE_SIZE;
        pix = pix_in;
        offs = 0;
        first = mip_expected.size();
        for (l = 0; l < MAX_LEVELS - 1; l++)
        begin
            if (size < 2)
                break;
            c = col_pos[l];
            r = row_pos[l];
            if (c + 1 >= size)
            begin
                col_pos[l] = 0;
                row_pos[l] = (r + 1 >= size) ? 0 : r + 1;
            end
            else
            begin
                col_pos[l] = c + 1;
            end
            half = size / 2;
            produced = 1'b0;
            if (c < 2 * half && r < 2 * half)
            begin
                if (c % 2 == 0)
                begin
                    left_pix[l] = pix;
                end
                else
                begin
                    idx = offs + c / 2;
                    for (k = 0; k < 4; k++)
                        pair[9*k +: 9] = {1'b0, left_pix[l][8*k +: 8]} + {1'b0, pix[8*k +: 8]};
                    if (idx < MAX_FACE_SIZE)
                    begin
                        if (r % 2 == 0)
                        begin
                            pair_sum_mem[idx] = pair;
                        end
                        else
                        begin
                            for (k = 0; k < 4; k++)
                            begin
                                t = pair_sum_mem[idx][9*k +: 9] + pair[9*k +: 9];
                                avg[8*k +: 8] = 8'((t + 2) >> 2);
                            end
                            res.face  = face;
                            res.level = 4'(l + 1);
                            res.col   = 10'(c / 2);
                            res.row   = 10'(r / 2);
                            res.red   = avg[7:0];
                            res.green = avg[15:8];
                            res.blue  = avg[23:16];
                            res.alpha = avg[31:24];
                            res.last  = 1'b0;
                            mip_expected = {mip_expected, res};
                            pix = avg;
                            produced = 1'b1;
                        end
                    end
                end
            end
            if (!produced)
                break;
            offs += MAX_FACE_SIZE >> (l + 1);
            size = half;
        end
        if (mip_expected.size() > first)
            mip_expected[mip_expected.size() - 1].last = 1'b1;
    endtask

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        mip_pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (mip_expected.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual tdata %h tuser %0d",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = mip_expected.pop_front();
                check_field("face_out",  want.face,  m_tuser);
                check_field("level",     want.level, m_tdata[3:0]);
                check_field("col",       want.col,   m_tdata[13:4]);
                check_field("row",       want.row,   m_tdata[23:14]);
                check_field("red_out",   want.red,   m_tdata[31:24]);
                check_field("green_out", want.green, m_tdata[39:32]);
                check_field("blue_out",  want.blue,  m_tdata[47:40]);
                check_field("alpha_out", want.alpha, m_tdata[55:48]);
                check_field("last",      want.last,  m_tlast);
            end
        end
    end

    // The receiver stalls in short random bursts, or for a long stretch on request.
    always @(negedge clk)
    begin : drive_ready
        int gap_left;
        int stall_left;
        if (stall_request > 0)
        begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_pixel(input logic [2:0] face, input logic [31:0] pix);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= face;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_mips(face, pix);
    endtask

    task automatic send_face(input int count, input logic [2:0] face);
        repeat (count) send_pixel(face, $urandom);
    endtask

    task automatic wait_for_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (mip_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        int l;
        wait_for_idle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_FACE_SIZE)
            model_size = value[11:0];
        else
            model_enable = value[0];
        for (l = 0; l < MAX_LEVELS; l++)
        begin
            col_pos[l] = 0;
            row_pos[l] = 0;
        end
    endtask

    task automatic test_disabled();
        write_register(ADDR_FACE_SIZE, 32'd4);
        send_face(4, 3'd2);
    endtask

    task automatic test_size_one();
        write_register(ADDR_FACE_SIZE, 32'd1);
        write_register(ADDR_MIP_ENABLE, 32'd1);
        send_face(2, 3'd1);
        write_register(ADDR_FACE_SIZE, 32'd0);
        send_face(2, 3'd4);
    endtask

    task automatic test_smallest_face();
        write_register(ADDR_FACE_SIZE, 32'd2);
        repeat (4) send_pixel(3'd7, 32'hFFFF_FFFF);
        repeat (4) send_pixel(3'd6, 32'h0000_0000);
        send_pixel(3'd5, 32'hFF01_0000);
        send_pixel(3'd5, 32'hFF01_0000);
        send_pixel(3'd5, 32'hFF01_0100);
        send_pixel(3'd5, 32'hFE00_0101);
    endtask

    task automatic test_oversize();
        write_register(ADDR_FACE_SIZE, 32'd4095);
        send_face(3, 3'd3);
        write_register(ADDR_FACE_SIZE, 32'd2048);
        send_face(2, 3'd0);
    endtask

    // A long receiver stall fills the output path and must hold off the input.
    task automatic test_backpressure();
        write_register(ADDR_FACE_SIZE, 32'd8);
        stall_request = 300;
        send_face(64, 3'd5);
        wait_for_idle();
        write_register(ADDR_FACE_SIZE, 32'd4);
        send_face(16, 3'd2);
        wait_for_idle();
    endtask

    task automatic test_random_faces(input int target);
        int sent;
        int size;
        int mode;
        int count;
        sent = 0;
        while (sent < target)
        begin
            size = ($urandom_range(0, 5) == 0) ? 8 : $urandom_range(2, 7);
            mode = $urandom_range(0, 9);
            if (mode == 0)
            begin
                write_register(ADDR_MIP_ENABLE, 32'd0);
                send_face($urandom_range(1, 4), 3'($urandom_range(0, 7)));
                write_register(ADDR_MIP_ENABLE, 32'd1);
            end
            else
            begin
                if (model_size != size || $urandom_range(0, 3) == 0)
                    write_register(ADDR_FACE_SIZE, size);
                count = (mode == 1) ? $urandom_range(1, size * size - 1) : size * size;
                send_face(count, 3'($urandom_range(0, 7)));
                sent += count;
                if (mode == 1)
                    write_register(ADDR_FACE_SIZE, size);
                else if ($urandom_range(0, 3) == 0)
                    wait_for_idle();
            end
        end
    endtask

    task automatic test_steady_tail();
        idle_on = 1'b0;
        write_register(ADDR_FACE_SIZE, 32'd4);
        send_face(16, 3'($urandom_range(0, 7)));
        write_register(ADDR_FACE_SIZE, 32'd5);
        send_face(25, 3'($urandom_range(0, 7)));
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_disabled();
        test_size_one();
        test_smallest_face();
        test_oversize();
        test_backpressure();
        test_random_faces(30);
        test_steady_tail();
        wait_for_idle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
src/mbc_pkg.sv
src/mbc_pair_ram.sv
src/mbc_avg_unit.sv
src/box_filter_mip_chain_top.sv
dv/tb.sv
